// File: design/fgs_pkg.sv
// Shared types, constants and helpers for the free gap statistics block.
// No dependencies; imported by every module of the block.
package fgs_pkg;

  localparam int unsigned CLUSTER_BITS_DEF = 32;
  localparam int unsigned REG_W            = 32;
  localparam int unsigned LIMIT_W          = 16;
  localparam int unsigned STAT_W           = 32;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned IN_DATA_W        = 8;
  localparam int unsigned OUT_DATA_W       = 5 * STAT_W;
  localparam logic [LIMIT_W-1:0] SMALL_LIMIT_RST = LIMIT_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXCL_A_BEGIN = 3'd0,
    CFG_EXCL_A_END   = 3'd1,
    CFG_EXCL_B_BEGIN = 3'd2,
    CFG_EXCL_B_END   = 3'd3,
    CFG_SMALL_LIMIT  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [REG_W-1:0]   excl_a_begin;
    logic [REG_W-1:0]   excl_a_end;
    logic [REG_W-1:0]   excl_b_begin;
    logic [REG_W-1:0]   excl_b_end;
    logic [LIMIT_W-1:0] small_gap_limit;
  } cfg_t;

  // first field in the highest bits once packed onto tdata
  typedef struct packed {
    logic [STAT_W-1:0] small_gap_clusters;
    logic [STAT_W-1:0] small_gap_total;
    logic [STAT_W-1:0] largest_gap;
    logic [STAT_W-1:0] free_cluster_total;
    logic [STAT_W-1:0] gap_total;
  } result_t;

  function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] a,
                                                input logic [STAT_W-1:0] b);
    logic [STAT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[STAT_W] ? {STAT_W{1'b1}} : s[STAT_W-1:0];
  endfunction

endpackage

// File: design/fgs_cfg_regs.sv
// Configuration register file: exclusion ranges and small gap limit.
// Depends on fgs_pkg.
module fgs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fgs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fgs_pkg::REG_W-1:0]     cfg_wdata_i,
  output fgs_pkg::cfg_t                 cfg_o
);
  import fgs_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_EXCL_A_BEGIN: cfg_d.excl_a_begin    = cfg_wdata_i;
        CFG_EXCL_A_END:   cfg_d.excl_a_end      = cfg_wdata_i;
        CFG_EXCL_B_BEGIN: cfg_d.excl_b_begin    = cfg_wdata_i;
        CFG_EXCL_B_END:   cfg_d.excl_b_end      = cfg_wdata_i;
        CFG_SMALL_LIMIT:  cfg_d.small_gap_limit = cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.excl_a_begin    <= '0;
      cfg_q.excl_a_end      <= '0;
      cfg_q.excl_b_begin    <= '0;
      cfg_q.excl_b_end      <= '0;
      cfg_q.small_gap_limit <= SMALL_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/fgs_run_core.sv
// Run tracker: cluster position, exclusion test, free run length and statistics.
// Depends on fgs_pkg; driven from the input register of free_gap_statistics.
module fgs_run_core #(
  parameter int unsigned CLUSTER_BITS = fgs_pkg::CLUSTER_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            used_i,
  input  logic            last_i,
  input  fgs_pkg::cfg_t   cfg_i,
  output fgs_pkg::result_t result_o
);
  import fgs_pkg::*;

  localparam int unsigned CmpW = (CLUSTER_BITS > REG_W) ? CLUSTER_BITS : REG_W;

  logic                    prev_used_q, prev_used_d;
  logic [CLUSTER_BITS-1:0] pos_q, pos_d;
  logic [CLUSTER_BITS-1:0] run_len_q, run_len_d;   // free clusters so far in run
  logic [CLUSTER_BITS-1:0] run_inc_q, run_inc_d;   // run_len_q + 1
  result_t                 stat_q, stat_d;

  logic [CmpW-1:0]         pos_ext;
  logic                    excl, used;
  logic                    close_on_used, do_close, is_short;
  logic [CLUSTER_BITS-1:0] cur_len, close_len;
  logic [CmpW-1:0]         len_ext;
  logic [STAT_W-1:0]       len32;

  assign pos_ext = CmpW'(pos_q);
  assign excl = (pos_ext >= CmpW'(cfg_i.excl_a_begin) && pos_ext < CmpW'(cfg_i.excl_a_end)) ||
                (pos_ext >= CmpW'(cfg_i.excl_b_begin) && pos_ext < CmpW'(cfg_i.excl_b_end));
  assign used = used_i | excl;

  assign close_on_used = !prev_used_q && used;
  assign do_close      = close_on_used || (last_i && !used);
  assign cur_len       = prev_used_q ? CLUSTER_BITS'(1) : run_inc_q;
  assign close_len     = close_on_used ? run_len_q : cur_len;
  assign len_ext       = CmpW'(close_len);

  if (CmpW > STAT_W) begin : g_sat
    assign len32 = (|len_ext[CmpW-1:STAT_W]) ? {STAT_W{1'b1}} : len_ext[STAT_W-1:0];
  end else begin : g_nosat
    assign len32 = len_ext[STAT_W-1:0];
  end

  assign is_short = len32 < STAT_W'(cfg_i.small_gap_limit);

  always_comb begin
    result_o = stat_q;
    if (do_close) begin
      result_o.gap_total          = sat_add(stat_q.gap_total, STAT_W'(1));
      result_o.free_cluster_total = sat_add(stat_q.free_cluster_total, len32);
      if (len32 > stat_q.largest_gap) begin
        result_o.largest_gap = len32;
      end
      if (is_short) begin
        result_o.small_gap_total    = sat_add(stat_q.small_gap_total, STAT_W'(1));
        result_o.small_gap_clusters = sat_add(stat_q.small_gap_clusters, len32);
      end
    end
  end

  always_comb begin
    prev_used_d = prev_used_q;
    pos_d       = pos_q;
    run_len_d   = run_len_q;
    run_inc_d   = run_inc_q;
    stat_d      = stat_q;
    if (step_i) begin
      if (last_i) begin
        prev_used_d = 1'b1;
        pos_d       = '0;
        run_len_d   = '0;
        run_inc_d   = CLUSTER_BITS'(1);
        stat_d      = '0;
      end else begin
        prev_used_d = used;
        pos_d       = pos_q + CLUSTER_BITS'(1);
        stat_d      = result_o;
        if (!used) begin
          run_len_d = cur_len;
          run_inc_d = cur_len + CLUSTER_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_used_q <= 1'b1;
      pos_q       <= '0;
      run_len_q   <= '0;
      run_inc_q   <= CLUSTER_BITS'(1);
      stat_q      <= '0;
    end else begin
      prev_used_q <= prev_used_d;
      pos_q       <= pos_d;
      run_len_q   <= run_len_d;
      run_inc_q   <= run_inc_d;
      stat_q      <= stat_d;
    end
  end

  a_volume_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> pos_q == '0 && prev_used_q && stat_q == '0)
    else $error("state not cleared after last cluster");

  a_small_le_gaps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_q.small_gap_total <= stat_q.gap_total &&
    stat_q.small_gap_clusters <= stat_q.free_cluster_total)
    else $error("small gap tallies exceed overall tallies");

  a_run_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_inc_q == run_len_q + CLUSTER_BITS'(1))
    else $error("run length shadow out of step");

endmodule

// File: design/free_gap_statistics.sv
// Top level of the free gap statistics block: input register, run core,
// configuration registers and result register. Depends on fgs_pkg,
// fgs_cfg_regs and fgs_run_core.
//
//  channel  | direction | payload                              | transfer
//  s_axis   | in        | tdata[0] cluster_used, tlast last    | tvalid & tready
//  m_axis   | out       | tdata five 32-bit statistics         | tvalid & tready
//  cfg      | in        | cfg_idx_i register, cfg_wdata_i data | cfg_we_i
//
// One item per cycle sustained; an item is taken into the input register and
// then updates the run state from there, in the same cycle as the result register
// loads the statistics of a volume when its last item steps the core.
// The input side stalls only while a finished result waits in the result
// register and the next item in the input register is again a last item.
// Reset clears the run state; the exclusion ranges reset to empty, limit to 16.
module free_gap_statistics #(
  parameter int unsigned CLUSTER_BITS = fgs_pkg::CLUSTER_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [fgs_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,   // [0] cluster_used
  input  logic                           s_axis_tlast_i,   // last_cluster
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [31:0] gap_total, [63:32] free_cluster_total, [95:64] largest_gap,
  // [127:96] small_gap_total, [159:128] small_gap_clusters
  output logic [fgs_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input  logic                           cfg_we_i,
  input  logic [fgs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fgs_pkg::REG_W-1:0]      cfg_wdata_i
);
  import fgs_pkg::*;

  cfg_t    cfg;
  result_t result;
  result_t res_q;
  logic    in_valid_q, in_used_q, in_last_q;
  logic    out_valid_q;
  logic    step, s_take;

  fgs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  fgs_run_core #(
    .CLUSTER_BITS (CLUSTER_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .used_i   (in_used_q),
    .last_i   (in_last_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign step            = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;
  assign s_take          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_used_q <= s_axis_tdata_i[0];
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = res_q;

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && in_last_q |=> out_valid_q)
    else $error("last cluster produced no result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step && in_last_q && out_valid_q && !m_axis_tready_i))
    else $error("pending result overwritten");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && in_last_q && out_valid_q && !m_axis_tready_i)
    else $error("input stalled without a waiting result");

endmodule
